// File: src/srgbe_pkg.sv
`default_nettype none

package srgbe_pkg;

    // curve store
    localparam int CURVE_ENTRIES = 65536;
    localparam int CURVE_AW      = $clog2(CURVE_ENTRIES);

    // geometry limits
    localparam int MAX_WIDTH  = 8192;
    localparam int WIDTH_LIM  = (MAX_WIDTH < 8192) ? MAX_WIDTH : 8192;
    localparam int HEIGHT_LIM = 8192;

    localparam int SIZE_W = 14;
    localparam int CNT_W  = 13;
    localparam int PAD_W  = 8;
    localparam int ADDR_W = 28;
    localparam int CHAN_W = 16;
    localparam int BYTE_W = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SIZE_W;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(480);
    localparam logic [PAD_W-1:0]  PAD_RST    = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH   = 2'd0,
        CFG_HEIGHT  = 2'd1,
        CFG_PADDING = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [BYTE_W-1:0] blue_out;
        logic [BYTE_W-1:0] green_out;
        logic [BYTE_W-1:0] red_out;
        logic [ADDR_W-1:0] byte_address;
        logic              frame_done;
    } t_pix_out;

    // one write into the curve store
    typedef struct packed {
        logic                we;
        logic [CURVE_AW-1:0] addr;
        logic [BYTE_W-1:0]   data;
    } t_rom_wr;

endpackage

`default_nettype wire

// File: src/srgbe_curve_gen.sv
`default_nettype none

// Builds the sRGB curve after reset, one entry at a time, in exact integers.
// Above the linear segment: byte >= k iff c^5 * 211^12 * 65535^7 >= B^12,
// B = 51200*k + 720885. Limb-serial bignum multiply and compare.
module srgbe_curve_gen import srgbe_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    output t_rom_wr      o_wr,
    output logic         o_done
);

    localparam int LIMBS   = 18;
    localparam int LIMB_W  = 16;
    localparam int LI_W    = $clog2(LIMBS);
    localparam int MUL_W   = 24;
    localparam int PROD_W  = LIMB_W + MUL_W + 1;
    localparam int CARRY_W = PROD_W - LIMB_W;

    localparam int KC_PASSES_A = 12;
    localparam int KC_PASSES   = KC_PASSES_A + 7;
    localparam int KC_FACTOR_A = 211;
    localparam int KC_FACTOR_B = 65535;
    localparam int LHS_PASSES  = 5;
    localparam int RHS_PASSES  = 11;
    localparam int PASS_W      = $clog2(KC_PASSES);

    localparam int B_BASE = 720885;
    localparam int B_STEP = 51200;

    localparam int LIN_LAST = 205;
    localparam int LIN_STEP = 1292;
    localparam int LIN_DEN  = 25600;
    localparam int REM_W    = 15;
    localparam int Q_W      = 4;

    localparam logic [BYTE_W-1:0] K_TOP = '1;

    typedef enum logic [3:0] {
        S_KC_INIT,
        S_KC_MUL,
        S_LIN,
        S_RHS_SET,
        S_RHS_MUL,
        S_LHS_MUL,
        S_CMP,
        S_WR,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [LIMB_W-1:0]     r_kc  [LIMBS];
    logic [LIMB_W-1:0]     r_lhs [LIMBS];
    logic [LIMB_W-1:0]     r_rhs [LIMBS];
    logic [LI_W-1:0]       r_li;
    logic [PASS_W-1:0]     r_cnt;
    logic [CARRY_W-1:0]    r_carry;
    logic [MUL_W-1:0]      r_b;
    logic [CURVE_AW-1:0]   r_c;
    logic [Q_W-1:0]        r_q;
    logic [REM_W-1:0]      r_rem;
    logic [BYTE_W-1:0]     r_k;
    logic                  r_lhs_ok;
    t_rom_wr               r_wr;
    logic                  r_done;

    logic [LIMB_W-1:0]     src_limb;
    logic [MUL_W-1:0]      mul;
    logic [PROD_W-1:0]     prod;
    logic                  pass_end;
    logic [BYTE_W-1:0]     k_inc;
    logic [MUL_W-1:0]      b_next;
    logic [REM_W-1:0]      rem_sum;
    logic                  limb_gt;
    logic                  limb_lt;

    always_comb begin
        src_limb = '0;
        mul      = '0;
        case (r_state)
            S_KC_MUL: begin
                src_limb = r_kc[r_li];
                mul = (r_cnt < PASS_W'(KC_PASSES_A)) ? MUL_W'(KC_FACTOR_A)
                                                      : MUL_W'(KC_FACTOR_B);
            end
            S_RHS_MUL: begin
                src_limb = r_rhs[r_li];
                mul      = r_b;
            end
            S_LHS_MUL: begin
                // first pass seeds from the constant
                src_limb = (r_cnt == '0) ? r_kc[r_li] : r_lhs[r_li];
                mul      = MUL_W'(r_c);
            end
            default: begin
                src_limb = '0;
                mul      = '0;
            end
        endcase
        prod     = PROD_W'(src_limb) * PROD_W'(mul) + PROD_W'(r_carry);
        pass_end = (r_li == LI_W'(LIMBS - 1));
        k_inc    = r_k + BYTE_W'(1);
        b_next   = MUL_W'(B_BASE) + MUL_W'(B_STEP) * MUL_W'(k_inc);
        rem_sum  = r_rem + REM_W'(LIN_STEP);
        limb_gt  = r_lhs[r_li] > r_rhs[r_li];
        limb_lt  = r_lhs[r_li] < r_rhs[r_li];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_KC_INIT;
            r_wr.we  <= 1'b0;
            r_done   <= 1'b0;
            r_lhs_ok <= 1'b0;
        end else begin
            // the store is written from the linear and write states only
            r_wr.we <= (r_state == S_LIN) || (r_state == S_WR);
            case (r_state)
                S_KC_INIT: begin
                    for (int i = 0; i < LIMBS; i++) begin
                        r_kc[i] <= (i == 0) ? LIMB_W'(1) : '0;
                    end
                    r_li    <= '0;
                    r_cnt   <= '0;
                    r_carry <= '0;
                    r_state <= S_KC_MUL;
                end
                S_KC_MUL: begin
                    r_kc[r_li] <= prod[LIMB_W-1:0];
                    r_carry    <= pass_end ? '0 : prod[PROD_W-1:LIMB_W];
                    r_li       <= pass_end ? '0 : r_li + LI_W'(1);
                    if (pass_end) begin
                        r_cnt <= r_cnt + PASS_W'(1);
                        if (r_cnt == PASS_W'(KC_PASSES - 1)) begin
                            r_c     <= '0;
                            r_q     <= '0;
                            r_rem   <= '0;
                            r_state <= S_LIN;
                        end
                    end
                end
                S_LIN: begin
                    r_wr.addr <= r_c;
                    r_wr.data <= BYTE_W'(r_q);
                    if (rem_sum >= REM_W'(LIN_DEN)) begin
                        r_rem <= rem_sum - REM_W'(LIN_DEN);
                        r_q   <= r_q + Q_W'(1);
                    end else begin
                        r_rem <= rem_sum;
                    end
                    r_c <= r_c + CURVE_AW'(1);
                    if (r_c == CURVE_AW'(LIN_LAST)) begin
                        r_k      <= '0;
                        r_lhs_ok <= 1'b0;
                        r_state  <= S_RHS_SET;
                    end
                end
                S_RHS_SET: begin
                    r_b <= b_next;
                    for (int i = 0; i < LIMBS; i++) begin
                        if (i == 0) begin
                            r_rhs[i] <= b_next[LIMB_W-1:0];
                        end else if (i == 1) begin
                            r_rhs[i] <= LIMB_W'(b_next[MUL_W-1:LIMB_W]);
                        end else begin
                            r_rhs[i] <= '0;
                        end
                    end
                    r_li     <= '0;
                    r_cnt    <= '0;
                    r_carry  <= '0;
                    r_state  <= S_RHS_MUL;
                end
                S_RHS_MUL: begin
                    r_rhs[r_li] <= prod[LIMB_W-1:0];
                    r_carry     <= pass_end ? '0 : prod[PROD_W-1:LIMB_W];
                    if (!pass_end) begin
                        r_li <= r_li + LI_W'(1);
                    end else if (r_cnt == PASS_W'(RHS_PASSES - 1)) begin
                        r_cnt <= '0;
                        if (r_lhs_ok) begin
                            r_li    <= LI_W'(LIMBS - 1);
                            r_state <= S_CMP;
                        end else begin
                            r_li    <= '0;
                            r_state <= S_LHS_MUL;
                        end
                    end else begin
                        r_li  <= '0;
                        r_cnt <= r_cnt + PASS_W'(1);
                    end
                end
                S_LHS_MUL: begin
                    r_lhs[r_li] <= prod[LIMB_W-1:0];
                    r_carry     <= pass_end ? '0 : prod[PROD_W-1:LIMB_W];
                    if (!pass_end) begin
                        r_li <= r_li + LI_W'(1);
                    end else if (r_cnt == PASS_W'(LHS_PASSES - 1)) begin
                        r_cnt    <= r_cnt + PASS_W'(1);
                        r_lhs_ok <= 1'b1;
                        r_li     <= LI_W'(LIMBS - 1);
                        r_state  <= S_CMP;
                    end else begin
                        r_li  <= '0;
                        r_cnt <= r_cnt + PASS_W'(1);
                    end
                end
                S_CMP: begin
                    // most significant limb first
                    if (limb_gt || (!limb_lt && r_li == '0)) begin
                        r_k <= k_inc;
                        r_state <= (k_inc == K_TOP) ? S_WR : S_RHS_SET;
                    end else if (limb_lt) begin
                        r_state <= S_WR;
                    end else begin
                        r_li <= r_li - LI_W'(1);
                    end
                end
                S_WR: begin
                    r_wr.addr <= r_c;
                    r_wr.data <= r_k;
                    r_lhs_ok  <= 1'b0;
                    r_li      <= '0;
                    r_cnt     <= '0;
                    r_carry   <= '0;
                    r_c       <= r_c + CURVE_AW'(1);
                    if (r_c == CURVE_AW'(CURVE_ENTRIES - 1)) begin
                        r_state <= S_DONE;
                    end else if (r_k != K_TOP) begin
                        r_state <= S_LHS_MUL;
                    end
                end
                S_DONE: begin
                    // set as the last write reaches the store
                    r_done <= 1'b1;
                end
                default: begin
                    r_state <= S_KC_INIT;
                end
            endcase
        end
    end

    assign o_wr   = r_wr;
    assign o_done = r_done;

endmodule

`default_nettype wire

// File: src/srgb_encode_rgb48_to_bgr24.sv
`default_nettype none

// sRGB encoder, 48-bit linear RGB in, 24-bit BGR bytes out. One pixel
// request per clock is taken and one result per clock delivered while the
// receiver keeps i_out_ready high; each request passes the curve store
// read, then the output register. The three channels look up a 65536 x 8
// curve held in two copies of a synchronous store, one read port pair on
// the first (blue, green) and one on the second (red), so no lookup ever
// waits on another. After reset the curve is built in place by an exact
// integer engine; until it is done no pixel request is taken
// (configuration writes are). Column, row and byte address counters follow
// each accepted pixel; row_padding bytes are skipped after each row and
// frame_done marks the last pixel of a frame, after which addressing
// restarts at zero. Width and height of zero act as one, and oversized
// values are clipped to the supported maximum. Configuration should only
// be written while no pixel is in flight.
module srgb_encode_rgb48_to_bgr24 import srgbe_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_pix_in               i_pix,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_pix_out                   o_res
);

    // configuration
    logic [SIZE_W-1:0]  r_width;
    logic [SIZE_W-1:0]  r_height;
    logic [PAD_W-1:0]   r_pad;

    // raster position
    logic [CNT_W-1:0]   r_col;
    logic [CNT_W-1:0]   r_row;
    logic [ADDR_W-1:0]  r_addr;
    logic [CNT_W-1:0]   n_col;
    logic [CNT_W-1:0]   n_row;
    logic [ADDR_W-1:0]  n_addr;

    // curve store, two copies for three lookups a cycle
    logic [BYTE_W-1:0]  r_rom_a [CURVE_ENTRIES];
    logic [BYTE_W-1:0]  r_rom_b [CURVE_ENTRIES];
    logic [BYTE_W-1:0]  r_rd_blue;
    logic [BYTE_W-1:0]  r_rd_green;
    logic [BYTE_W-1:0]  r_rd_red;

    // lookup stage and output register
    logic               r_s1_valid;
    logic [ADDR_W-1:0]  r_s1_addr;
    logic               r_s1_done;
    logic               r_out_valid;
    t_pix_out           r_out;

    t_rom_wr            rom_wr;
    logic               rom_done;

    logic               in_acc;
    logic               s1_adv;
    logic [SIZE_W-1:0]  w_eff;
    logic [SIZE_W-1:0]  h_eff;
    logic               row_end;
    logic               frame_end;
    logic [ADDR_W-1:0]  addr_step;

    srgbe_curve_gen u_curve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_wr    (rom_wr),
        .o_done  (rom_done)
    );

    // the lookup stage moves on when the output register is free or draining
    assign s1_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = rom_done && (!r_s1_valid || s1_adv);
    assign in_acc     = i_in_valid && o_in_ready;

    // effective frame size: zero acts as one, clip to the limits
    always_comb begin
        if (r_width == '0) begin
            w_eff = SIZE_W'(1);
        end else if (r_width > SIZE_W'(WIDTH_LIM)) begin
            w_eff = SIZE_W'(WIDTH_LIM);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = SIZE_W'(1);
        end else if (r_height > SIZE_W'(HEIGHT_LIM)) begin
            h_eff = SIZE_W'(HEIGHT_LIM);
        end else begin
            h_eff = r_height;
        end
    end

    // next raster position; a size change applies at once
    always_comb begin
        row_end   = (SIZE_W'(r_col) + SIZE_W'(1)) >= w_eff;
        frame_end = row_end && ((SIZE_W'(r_row) + SIZE_W'(1)) >= h_eff);
        addr_step = r_addr + ADDR_W'(3);
        if (frame_end) begin
            n_col  = '0;
            n_row  = '0;
            n_addr = '0;
        end else if (row_end) begin
            n_col  = '0;
            n_row  = r_row + CNT_W'(1);
            n_addr = addr_step + ADDR_W'(r_pad);
        end else begin
            n_col  = r_col + CNT_W'(1);
            n_row  = r_row;
            n_addr = addr_step;
        end
    end

    // curve store: filled once after reset, read on each request
    always_ff @(posedge i_clk) begin
        if (rom_wr.we) begin
            r_rom_a[rom_wr.addr] <= rom_wr.data;
            r_rom_b[rom_wr.addr] <= rom_wr.data;
        end
        if (in_acc) begin
            r_rd_blue  <= r_rom_a[i_pix.blue_in];
            r_rd_green <= r_rom_a[i_pix.green_in];
            r_rd_red   <= r_rom_b[i_pix.red_in];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_pad    <= PAD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:   r_width  <= i_cfg_data;
                CFG_HEIGHT:  r_height <= i_cfg_data;
                CFG_PADDING: r_pad    <= i_cfg_data[PAD_W-1:0];
                default: begin
                    // unmapped index: dropped
                end
            endcase
        end
    end

    // raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_addr <= '0;
        end else if (in_acc) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_addr <= n_addr;
        end
    end

    // lookup stage; the store read data holds while this stage stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc || (r_s1_valid && !s1_adv);
        end
        if (in_acc) begin
            r_s1_addr <= r_addr;
            r_s1_done <= frame_end;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
        if (s1_adv && r_s1_valid) begin
            r_out.blue_out     <= r_rd_blue;
            r_out.green_out    <= r_rd_green;
            r_out.red_out      <= r_rd_red;
            r_out.byte_address <= r_s1_addr;
            r_out.frame_done   <= r_s1_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

`default_nettype wire

// File: src/srgbe_checker.sv
`default_nettype none

module srgbe_checker import srgbe_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_ready,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire t_pix_out              o_res
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pend;
    logic       r_after_done;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // requests taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend       <= '0;
            r_after_done <= 1'b1;
        end else begin
            case ({in_acc, out_acc})
                2'b10:   r_pend <= r_pend + 2'd1;
                2'b01:   r_pend <= r_pend - 2'd1;
                default: r_pend <= r_pend;
            endcase
            if (out_acc) begin
                r_after_done <= o_res.frame_done;
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_res))
        else $error("result changed or dropped while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("handshake active straight after reset");

    a_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3 && (!o_out_valid || r_pend != 2'd0))
        else $error("result count out of step with requests");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_after_done |-> o_res.byte_address == '0)
        else $error("new frame does not start at address zero");

endmodule

bind srgb_encode_rgb48_to_bgr24 srgbe_checker u_srgbe_checker (.*);

`default_nettype wire

// File: tb/srgbe_checker.sv
`timescale 1ns / 1ps

module srgbe_tb_checker import srgbe_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire t_pix_in               i_pix,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire t_pix_out              i_res,
    output int                         o_errors,
    output int                         o_pending
);

    localparam int LIN_LAST   = 205;       // last code on the linear segment
    localparam int SLOPE_NUM  = 1292;
    localparam int SLOPE_DIV  = 25600;
    localparam int CURVE_DEN  = 69139425;  // 1055 * 65535
    localparam int LEVEL_STEP = 256000;
    localparam int LEVEL_OFS  = 3604425;   // 55 * 65535
    localparam int FULL_SCALE = 65535;
    localparam int MAX_SHOWN  = 10;

    // c^5 * D^12 stays below 2^393
    typedef bit [447:0] t_big;

    t_big den_pow12;
    t_big level_bound [1:255];

    logic [SIZE_W-1:0] cfg_width  = WIDTH_RST;
    logic [SIZE_W-1:0] cfg_height = HEIGHT_RST;
    logic [PAD_W-1:0]  cfg_pad    = PAD_RST;
    int                col_pos    = 0;
    int                row_pos    = 0;
    logic [ADDR_W-1:0] addr_next  = '0;

    t_pix_out pixel_q [$];
    t_pix_out want;
    int       err_cnt = 0;

    // byte >= k  iff  c^5 * D^12 >= (256000*k + 55*65535)^12 * 65535^5
    initial begin
        t_big acc;
        den_pow12 = 1;
        repeat (12) den_pow12 = den_pow12 * t_big'(CURVE_DEN);
        for (int k = 1; k <= 255; k++) begin
            acc = 1;
            repeat (12) acc = acc * t_big'(LEVEL_STEP * k + LEVEL_OFS);
            repeat (5) acc = acc * t_big'(FULL_SCALE);
            level_bound[k] = acc;
        end
    end

    function automatic logic [BYTE_W-1:0] gamma_byte(input logic [CHAN_W-1:0] c);
        t_big lhs;
        int   lo, hi, mid;
        if (int'(c) <= LIN_LAST)
            return BYTE_W'((SLOPE_NUM * int'(c)) / SLOPE_DIV);
        lhs = den_pow12;
        repeat (5) lhs = lhs * t_big'(c);
        lo = 0;
        hi = 255;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (lhs >= level_bound[mid])
                lo = mid;
            else
                hi = mid - 1;
        end
        return BYTE_W'(lo);
    endfunction

    // encodes one pixel and advances the raster position
    function automatic t_pix_out encode_pixel(input t_pix_in p);
        t_pix_out r;
        int       w, h;
        w = (cfg_width == '0) ? 1 : int'(cfg_width);
        if (w > WIDTH_LIM) w = WIDTH_LIM;
        h = (cfg_height == '0) ? 1 : int'(cfg_height);
        if (h > HEIGHT_LIM) h = HEIGHT_LIM;
        r.blue_out     = gamma_byte(p.blue_in);
        r.green_out    = gamma_byte(p.green_in);
        r.red_out      = gamma_byte(p.red_in);
        r.byte_address = addr_next;
        r.frame_done   = 1'b0;
        addr_next = addr_next + ADDR_W'(3);
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            addr_next = addr_next + ADDR_W'(cfg_pad);
            if (row_pos + 1 >= h) begin
                row_pos      = 0;
                addr_next    = '0;
                r.frame_done = 1'b1;
            end else begin
                row_pos = row_pos + 1;
            end
        end else begin
            col_pos = col_pos + 1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_width  = WIDTH_RST;
            cfg_height = HEIGHT_RST;
            cfg_pad    = PAD_RST;
            col_pos    = 0;
            row_pos    = 0;
            addr_next  = '0;
            pixel_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WIDTH:   cfg_width  = i_cfg_data[SIZE_W-1:0];
                    CFG_HEIGHT:  cfg_height = i_cfg_data[SIZE_W-1:0];
                    CFG_PADDING: cfg_pad    = i_cfg_data[PAD_W-1:0];
                    default: ;
                endcase
            end
            // a result never leaves in the cycle its request is taken, so drain first
            if (i_out_valid && i_out_ready) begin
                if (pixel_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_SHOWN)
                        $display({"%0t: result with no request outstanding: ",
                                  "b=%0d g=%0d r=%0d addr=%0d done=%0b"},
                                 $realtime, i_res.blue_out, i_res.green_out,
                                 i_res.red_out, i_res.byte_address,
                                 i_res.frame_done);
                end else begin
                    want = pixel_q.pop_front();
                    if (i_res.blue_out !== want.blue_out ||
                        i_res.green_out !== want.green_out ||
                        i_res.red_out !== want.red_out ||
                        i_res.byte_address !== want.byte_address ||
                        i_res.frame_done !== want.frame_done) begin
                        err_cnt++;
                        if (err_cnt <= MAX_SHOWN)
                            $display({"%0t: pixel mismatch: expected ",
                                      "b=%0d g=%0d r=%0d addr=%0d done=%0b, ",
                                      "got b=%0d g=%0d r=%0d addr=%0d done=%0b"},
                                     $realtime, want.blue_out, want.green_out,
                                     want.red_out, want.byte_address,
                                     want.frame_done,
                                     i_res.blue_out, i_res.green_out,
                                     i_res.red_out, i_res.byte_address,
                                     i_res.frame_done);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                pixel_q.push_back(encode_pixel(i_pix));
        end
        o_pending <= pixel_q.size();
        o_errors  <= err_cnt;
    end

endmodule

// File: tb/srgb_encode_rgb48_to_bgr24_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the sRGB encoder. The checker beside the block
// watches both channels and the config port, predicts every pixel and counts
// failures; this module only drives requests, back-pressure and config.
module srgb_encode_rgb48_to_bgr24_tb;
    import srgbe_pkg::*;

    // index 3 has no register behind it; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 1150;
    localparam int LONG_HOLD    = 400;    // receiver hold-off, cycles
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 8;      // leave some slack

    typedef enum int {
        IDLE_RX_HEAVY,   // sender gaps 12 %, receiver stalls 84 %
        IDLE_TX_HEAVY,   // the other way round
        IDLE_NONE
    } t_idle_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_pix_in               i_pix       = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_pix_out              o_res;

    int         errors;
    int         pending;
    t_idle_mode idle_mode = IDLE_RX_HEAVY;
    int         hold_reqs = 0;

    // codes around the knee of the curve, both ends and alternating bits
    logic [CHAN_W-1:0] knee_vals [0:12] = '{
        16'd0, 16'd1, 16'd204, 16'd205, 16'd206, 16'd207, 16'd1000,
        16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFF
    };

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    srgb_encode_rgb48_to_bgr24 DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pix       (i_pix),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (o_res)
    );

    srgbe_tb_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_pix       (i_pix),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_res       (o_res),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    function automatic int tx_gap_pct();
        case (idle_mode)
            IDLE_RX_HEAVY: return 12;
            IDLE_TX_HEAVY: return 84;
            default:       return 0;
        endcase
    endfunction

    function automatic int rx_stall_pct();
        case (idle_mode)
            IDLE_RX_HEAVY: return 84;
            IDLE_TX_HEAVY: return 12;
            default:       return 0;
        endcase
    endfunction

    // Receiver side. A bump of hold_reqs starts a long hold-off, counted
    // here, so the two-deep pipe fills and the block drops o_in_ready while
    // the sender keeps offering requests.
    initial begin
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != holds_seen) begin
                holds_seen = hold_reqs;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= rx_stall_pct());
            end
        end
    end

    // Offers one pixel request after a random gap and returns at the edge
    // that accepts it; valid is left high so back-to-back requests never
    // see it dip.
    task automatic send_pixel(input t_pix_in p);
        while ($urandom_range(0, 99) < tx_gap_pct()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pix      <= p;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Every request yields exactly one result, so an empty expectation queue
    // means the block is idle and may be reconfigured.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Writes all three registers, then a stray write to the spare index.
    task automatic set_geometry(input logic [CFG_DATA_W-1:0] w, h, pad);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_PADDING;
        i_cfg_data <= pad;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SPARE;
        i_cfg_data <= CFG_DATA_W'($urandom());
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return CHAN_W'($urandom_range(0, 300));   // knee region
            1:       return $urandom_range(0, 1) ? '1 : '0;
            default: return CHAN_W'($urandom());
        endcase
    endfunction

    // Mostly tiny frames so frame ends come often; now and then zero,
    // the limit itself and values past it.
    function automatic logic [CFG_DATA_W-1:0] rand_size();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return CFG_DATA_W'(8192);
            3:       return CFG_DATA_W'(8191);
            default: return CFG_DATA_W'($urandom_range(1, 9));
        endcase
    endfunction

    // upper bits are random so the 8-bit mask on padding is exercised
    function automatic logic [CFG_DATA_W-1:0] rand_pad();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return {(CFG_DATA_W - PAD_W)'($urandom()), {PAD_W{1'b1}}};
            default: return CFG_DATA_W'($urandom());
        endcase
    endfunction

    initial begin
        int sent;
        int phase_len;
        int drain;
        bit held;
        sent = 0;
        held = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Reset geometry (640 x 480) first: one request per
        // corner code, channels rotated so each sees every code. The block
        // builds its curve after reset, so the first accept comes late.
        for (int i = 0; i < 13; i++)
            send_pixel(t_pix_in'{red_in:   knee_vals[i],
                                 green_in: knee_vals[(i + 5) % 13],
                                 blue_in:  knee_vals[(i + 9) % 13]});

        // zero width and height act as one: every pixel ends a frame at 0;
        // padding data of all ones must be cut to 255
        wait_idle();
        set_geometry('0, '0, '1);
        repeat (3) send_pixel({rand_chan(), rand_chan(), rand_chan()});

        // 3 x 2 frame with padding, run across a row end
        wait_idle();
        set_geometry(CFG_DATA_W'(3), CFG_DATA_W'(2), CFG_DATA_W'(7));
        repeat (4) send_pixel({rand_chan(), rand_chan(), rand_chan()});

        // narrower width mid-row: the row ends on the next pixel
        wait_idle();
        set_geometry(CFG_DATA_W'(2), CFG_DATA_W'(2), CFG_DATA_W'(7));
        repeat (3) send_pixel({rand_chan(), rand_chan(), rand_chan()});

        // oversize on both axes clips to the limits
        wait_idle();
        set_geometry('1, '1, CFG_DATA_W'(255));
        repeat (2) send_pixel({rand_chan(), rand_chan(), rand_chan()});

        // Random part in phases; each phase waits for the block to drain,
        // picks a new geometry and sends a burst. Idling shifts by thirds.
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            set_geometry(rand_size(), rand_size(), rand_pad());
            phase_len = $urandom_range(20, 80);
            if (!held && sent >= 2 * RANDOM_ITEMS / 3) begin
                held = 1'b1;
                hold_reqs <= hold_reqs + 1;
            end
            for (int j = 0; j < phase_len; j++) begin
                idle_mode <= (sent < RANDOM_ITEMS / 3)     ? IDLE_RX_HEAVY :
                             (sent < 2 * RANDOM_ITEMS / 3) ? IDLE_TX_HEAVY : IDLE_NONE;
                send_pixel({rand_chan(), rand_chan(), rand_chan()});
                sent++;
            end
        end

        // drain, then a few cycles more to catch any stray result
        i_in_valid <= 1'b0;
        drain = 0;
        @(posedge i_clk);
        while (pending != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // The curve build after reset alone takes about 73 ms; the random traffic
    // adds little. This is over five times that.
    initial begin
        #400_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
